@@ hw/rtl/dlr_pkg.sv @@
// ============================================================================
// dlr_pkg: shared types and constants for the dirty rectangle ledger
// Holds the item formats of both channels, the stored entry layout, the
// opcode and sequencer state codes, and the compare unit result.
// ============================================================================
`timescale 1ns / 1ps

package dlr_pkg;

  // Field widths fixed by the item formats.
  localparam int COORD_W = 12;
  localparam int SUM_W   = COORD_W + 1;
  localparam int TIME_W  = 48;
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  // Item opcodes. The fourth code changes nothing.
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_PATCH = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  // One input item.
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_w;
    logic [COORD_W-1:0] rect_h;
    logic [TIME_W-1:0]  now_us;
    logic               last_in_batch;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [COUNT_W-1:0] cleared_count;
    logic [COUNT_W-1:0] active_count;
    logic               batch_done;
  } out_item_t;

  // One stored rectangle with its time stamp.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [TIME_W-1:0]  time_us;
  } entry_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic overlap;
    logic older;
  } cmp_res_t;

endpackage

@@ hw/rtl/dlr_ram.sv @@
// ============================================================================
// dlr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module dlr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and read data register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/dlr_cmp_unit.sv @@
// ============================================================================
// dlr_cmp_unit: shared compare unit of the ledger
// Tests one stored entry against the probe rectangle with a strict interval
// overlap on both axes, and checks whether its time is below the running
// minimum.
// ============================================================================
`timescale 1ns / 1ps

module dlr_cmp_unit (
  input  dlr_pkg::entry_t              entry_i,
  input  dlr_pkg::in_item_t            probe_i,
  input  logic [dlr_pkg::TIME_W-1:0]   tmin_i,
  output dlr_pkg::cmp_res_t            res_o
);
  import dlr_pkg::*;

  logic [SUM_W-1:0] probe_right;
  logic [SUM_W-1:0] probe_bottom;
  logic [SUM_W-1:0] entry_right;
  logic [SUM_W-1:0] entry_bottom;

  // Far edges, one bit wider so the sums never wrap.
  always_comb begin
    probe_right  = SUM_W'(probe_i.rect_x) + SUM_W'(probe_i.rect_w);
    probe_bottom = SUM_W'(probe_i.rect_y) + SUM_W'(probe_i.rect_h);
    entry_right  = SUM_W'(entry_i.left) + SUM_W'(entry_i.width);
    entry_bottom = SUM_W'(entry_i.top) + SUM_W'(entry_i.height);
  end

  // Strict overlap on both axes: rectangles that only touch at an edge do
  // not overlap.
  always_comb begin
    res_o.overlap = (SUM_W'(entry_i.left) < probe_right) &&
                    (SUM_W'(probe_i.rect_x) < entry_right) &&
                    (SUM_W'(entry_i.top) < probe_bottom) &&
                    (SUM_W'(probe_i.rect_y) < entry_bottom);
    res_o.older   = entry_i.time_us < tmin_i;
  end

endmodule

@@ hw/rtl/dirty_rect_ledger.sv @@
// ============================================================================
// dirty_rect_ledger: table of pending screen rectangles
// Adds rectangles into free slots (evicting the oldest when full), drops
// entries that overlap a patch rectangle, and clears the whole table.
// ============================================================================
//
//   Channel   Signals                              Moves
//   --------  -----------------------------------  -------------------------
//   input     in_valid_i, in_stall_o, in_item_i    one command item
//   output    out_valid_o, out_stall_i, out_item_o one result per command
//
// An add or a patch walks the table one entry per cycle through the entry
// RAM and the shared compare unit; the result register loads after the walk,
// which ends early for an add that finds a free slot. A clear or an unused
// opcode skips the walk. The block returns to idle as the result register
// loads. The RAM read port sets the walk at one entry per cycle. After reset
// the table is empty and the block is ready at once. The next item is
// accepted while a result waits in the output register; a stalled output
// holds the block in its finishing state.
`timescale 1ns / 1ps

module dirty_rect_ledger #(
  parameter int ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dlr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dlr_pkg::out_item_t out_item_o
);
  import dlr_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ENT_W = $bits(entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] ENT_COUNT = CNT_W'(ENTRIES);

  state_e state_q, state_d;

  // Control registers.
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic               cmp_v_q, cmp_v_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   active_q, active_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers.
  in_item_t           req_q, req_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [TIME_W-1:0]  tmin_q, tmin_d;
  logic [IDX_W-1:0]   pick_q, pick_d;
  logic               free_q, free_d;
  logic [CNT_W-1:0]   cleared_q, cleared_d;
  out_item_t          out_q, out_d;

  // Sequencer controls.
  logic accept;
  logic issue_rd;
  logic eval;
  logic out_load;
  logic walk_done;

  // Entry RAM and compare unit.
  logic       ram_we;
  entry_t     ram_wentry;
  logic [ENT_W-1:0] ram_rdata;
  entry_t     rd_entry;
  cmp_res_t   cmp_res;

  dlr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_dlr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pick_q),
    .wdata_i (ram_wentry),
    .re_i    (issue_rd),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  dlr_cmp_unit u_dlr_cmp_unit (
    .entry_i (rd_entry),
    .probe_i (req_q),
    .tmin_i  (tmin_q),
    .res_o   (cmp_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_d.opcode == OP_ADD || req_d.opcode == OP_PATCH) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = (state_q == ST_IDLE) && in_valid_i;
    issue_rd   = (state_q == ST_WALK) && (rd_cnt_q < ENT_COUNT);
    eval       = (state_q == ST_WALK) && cmp_v_q;
    out_load   = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);
  end

  // Walk over the table and the final update of each item.
  always_comb begin
    req_d       = req_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_v_d     = issue_rd;
    cmp_idx_d   = rd_cnt_q[IDX_W-1:0];
    valid_d     = valid_q;
    active_d    = active_q;
    tmin_d      = tmin_q;
    pick_d      = pick_q;
    free_d      = free_q;
    cleared_d   = cleared_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    walk_done   = 1'b0;
    ram_we      = 1'b0;

    if (accept) begin
      req_d     = in_item_i;
      rd_cnt_d  = '0;
      free_d    = 1'b0;
      pick_d    = '0;
      cleared_d = '0;
    end else if (issue_rd) begin
      rd_cnt_d = rd_cnt_q + 1'b1;
    end

    // One entry per cycle from the RAM read register.
    if (eval) begin
      if (req_q.opcode == OP_ADD) begin
        if (!valid_q[cmp_idx_q]) begin
          pick_d    = cmp_idx_q;
          free_d    = 1'b1;
          walk_done = 1'b1;
        end else begin
          if (cmp_idx_q == '0 || cmp_res.older) begin
            tmin_d = rd_entry.time_us;
            pick_d = cmp_idx_q;
          end
          walk_done = (cmp_idx_q == LAST_IDX);
        end
      end else begin
        if (valid_q[cmp_idx_q] && cmp_res.overlap) begin
          valid_d[cmp_idx_q] = 1'b0;
          cleared_d          = cleared_q + 1'b1;
        end
        walk_done = (cmp_idx_q == LAST_IDX);
      end
    end

    // Commit the item and load the result register.
    if (out_load) begin
      out_d = '0;
      unique case (req_q.opcode)
        OP_ADD: begin
          ram_we          = 1'b1;
          valid_d[pick_q] = 1'b1;
          if (free_q) begin
            active_d = active_q + 1'b1;
          end
          out_d.slot    = SLOT_W'(pick_q);
          out_d.evicted = !free_q;
        end
        OP_PATCH: begin
          active_d            = active_q - cleared_q;
          out_d.cleared_count = COUNT_W'(cleared_q);
          out_d.batch_done    = req_q.last_in_batch;
        end
        OP_CLEAR: begin
          valid_d             = '0;
          active_d            = '0;
          out_d.cleared_count = COUNT_W'(active_q);
        end
        default: begin
        end
      endcase
      out_d.active_count = COUNT_W'(active_d);
      out_valid_d        = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Rectangle and time written on an add.
  always_comb begin
    ram_wentry.left    = req_q.rect_x;
    ram_wentry.top     = req_q.rect_y;
    ram_wentry.width   = req_q.rect_w;
    ram_wentry.height  = req_q.rect_h;
    ram_wentry.time_us = req_q.now_us;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      cmp_v_q     <= 1'b0;
      valid_q     <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_v_q     <= cmp_v_d;
      valid_q     <= valid_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cmp_idx_q <= cmp_idx_d;
    tmin_q    <= tmin_d;
    pick_q    <= pick_d;
    free_q    <= free_d;
    cleared_q <= cleared_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hw/rtl/dlr_checker.sv @@
// ============================================================================
// dlr_checker: port-level checks for the dirty rectangle ledger
// Watches the ledger's channels over time and is bound to the top level.
// ============================================================================
`timescale 1ns / 1ps

module dlr_checker #(
  parameter int ENTRIES = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dlr_pkg::out_item_t out_item_o
);
  import dlr_pkg::*;

  // The block is busy in the cycle after it takes an item.
  busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o
  ) else $error("ledger ready right after accepting an item");

  // A stalled result stays and holds its value.
  result_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o)
  ) else $error("stalled result changed or vanished");

  // A new result follows a cycle in which the block was working.
  result_after_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result appeared without work in progress");

  // An eviction only comes from an add, which clears nothing.
  evict_is_add: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.evicted |->
      out_item_o.cleared_count == '0 && out_item_o.batch_done == 1'b0
  ) else $error("eviction reported on a non-add result");

  // The table never reports more entries than it has.
  active_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ENTRIES > 31) || (int'(out_item_o.active_count) <= ENTRIES)
  ) else $error("active count above table size");

endmodule

bind dirty_rect_ledger dlr_checker #(.ENTRIES(ENTRIES)) u_dlr_checker (.*);

@@ bench/dirty_rect_ledger_tb.sv @@
// ============================================================================
// dirty_rect_ledger_tb: self-checking bench for the dirty rectangle ledger
// Drives add, patch, clear and spare-opcode items through the valid/stall
// channels with random gaps on both sides. A scoreboard keeps its own copy of
// the rectangle table, predicts every result and checks results in order.
// ============================================================================
`timescale 1ns / 1ps

// Scoreboard: a shadow copy of the rectangle table and the results it predicts.
class ledger_board;
  localparam int SLOTS       = 16;
  localparam int MAX_REPORTS = 40;

  bit        live_q   [SLOTS];
  bit [11:0] left_q   [SLOTS];
  bit [11:0] top_q    [SLOTS];
  bit [11:0] wide_q   [SLOTS];
  bit [11:0] tall_q   [SLOTS];
  bit [47:0] stamp_q  [SLOTS];

  dlr_pkg::out_item_t awaited_q[$];

  int errors;
  int checked;
  int adds;
  int evictions;
  int patches;
  int patch_hits;
  int clears;
  int spares;

  function int pending();
    return awaited_q.size();
  endfunction

  function int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (live_q[i]) n++;
    end
    return n;
  endfunction

  // Strict interval test on both axes, sums carried at coordinate width + 1.
  function bit overlaps(int i, dlr_pkg::in_item_t p);
    bit [12:0] p_right;
    bit [12:0] p_bottom;
    bit [12:0] e_right;
    bit [12:0] e_bottom;
    p_right  = 13'(p.rect_x) + 13'(p.rect_w);
    p_bottom = 13'(p.rect_y) + 13'(p.rect_h);
    e_right  = 13'(left_q[i]) + 13'(wide_q[i]);
    e_bottom = 13'(top_q[i]) + 13'(tall_q[i]);
    return (13'(left_q[i]) < p_right) && (13'(p.rect_x) < e_right) &&
           (13'(top_q[i]) < p_bottom) && (13'(p.rect_y) < e_bottom);
  endfunction

  // Applies one accepted item to the shadow table and queues its result.
  function void note_command(dlr_pkg::in_item_t cmd);
    dlr_pkg::out_item_t res;
    int        pick;
    bit        found;
    bit [47:0] oldest;
    int        dropped;
    res     = '0;
    pick    = 0;
    found   = 1'b0;
    oldest  = '0;
    dropped = 0;
    case (cmd.opcode)
      dlr_pkg::OP_ADD: begin
        // First free slot wins; a full table gives up its oldest entry.
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (!live_q[i]) begin
            pick  = i;
            found = 1'b1;
          end else if (i == 0 || stamp_q[i] < oldest) begin
            oldest = stamp_q[i];
            pick   = i;
          end
        end
        live_q[pick]  = 1'b1;
        left_q[pick]  = cmd.rect_x;
        top_q[pick]   = cmd.rect_y;
        wide_q[pick]  = cmd.rect_w;
        tall_q[pick]  = cmd.rect_h;
        stamp_q[pick] = cmd.now_us;
        res.slot      = pick[3:0];
        res.evicted   = !found;
        adds++;
        if (!found) evictions++;
      end
      dlr_pkg::OP_PATCH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live_q[i] && overlaps(i, cmd)) begin
            live_q[i] = 1'b0;
            dropped++;
          end
        end
        res.cleared_count = dropped[4:0];
        res.batch_done    = cmd.last_in_batch;
        patches++;
        patch_hits += dropped;
      end
      dlr_pkg::OP_CLEAR: begin
        dropped = live_count();
        for (int i = 0; i < SLOTS; i++) live_q[i] = 1'b0;
        res.cleared_count = dropped[4:0];
        clears++;
      end
      default: begin
        spares++;
      end
    endcase
    res.active_count = 5'(live_count());
    awaited_q.push_back(res);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("result %0d field %s: got %0h, expected %0h",
                       checked, name, got, want));
    end
  endtask

  // Compares one accepted result with the oldest prediction.
  task check_result(dlr_pkg::out_item_t got);
    dlr_pkg::out_item_t want;
    if (awaited_q.size() == 0) begin
      report($sformatf("result with nothing awaited: slot %0d active %0d",
                       got.slot, got.active_count));
      return;
    end
    want = awaited_q.pop_front();
    compare_field("slot", 32'(got.slot), 32'(want.slot));
    compare_field("evicted", 32'(got.evicted), 32'(want.evicted));
    compare_field("cleared_count", 32'(got.cleared_count), 32'(want.cleared_count));
    compare_field("active_count", 32'(got.active_count), 32'(want.active_count));
    compare_field("batch_done", 32'(got.batch_done), 32'(want.batch_done));
    checked++;
  endtask
endclass

module dirty_rect_ledger_tb;
  import dlr_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 40;
  localparam int IN_W         = $bits(in_item_t);
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  ledger_board board;
  bit          calm        = 1'b0;
  int unsigned cycle_count = 0;
  bit [47:0]   clock_us    = '0;
  int          batch_left  = 0;

  dirty_rect_ledger u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Clock.
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Receiver stalls at random except during the calm stretch.
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 29);
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) board.check_result(out_item_o);
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, board.pending());
    $display("dirty_rect_ledger regression: fail");
    $finish;
  end

  function automatic in_item_t make_cmd(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
                                        logic [COORD_W-1:0] y, logic [COORD_W-1:0] w,
                                        logic [COORD_W-1:0] h, logic [TIME_W-1:0] t,
                                        logic last);
    in_item_t cmd;
    cmd.opcode        = op;
    cmd.rect_x        = x;
    cmd.rect_y        = y;
    cmd.rect_w        = w;
    cmd.rect_h        = h;
    cmd.now_us        = t;
    cmd.last_in_batch = last;
    return cmd;
  endfunction

  function automatic logic [TIME_W-1:0] wide_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // Positions cluster in a small window so that rectangles collide often.
  function automatic logic [COORD_W-1:0] pick_pos();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return COORD_W'($urandom_range(0, 511));
    if (roll < 95) return COORD_W'($urandom_range(0, 4095));
    return roll[0] ? '1 : '0;
  endfunction

  function automatic logic [COORD_W-1:0] pick_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return COORD_W'($urandom_range(1, 200));
    if (roll < 88) return '0;
    if (roll < 95) return COORD_W'($urandom_range(0, 4095));
    return '1;
  endfunction

  // Time mostly runs forward, with ties and the odd arbitrary value.
  function automatic logic [TIME_W-1:0] next_stamp();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return wide_time();
    if (roll >= 15) clock_us += TIME_W'($urandom_range(1, 1000));
    return clock_us;
  endfunction

  // Mostly adds and well-formed patch batches, some clears, spare codes and noise.
  function automatic in_item_t random_cmd();
    int       roll;
    in_item_t cmd;
    roll = $urandom_range(0, 99);
    if (batch_left > 0) begin
      batch_left--;
      return make_cmd(OP_PATCH, pick_pos(), pick_pos(), pick_span(), pick_span(),
                      wide_time(), batch_left == 0);
    end
    if (roll < 66) begin
      return make_cmd(OP_ADD, pick_pos(), pick_pos(), pick_span(), pick_span(),
                      next_stamp(), 1'($urandom_range(0, 1)));
    end
    if (roll < 84) begin
      batch_left = $urandom_range(0, 4);
      return make_cmd(OP_PATCH, pick_pos(), pick_pos(), pick_span(), pick_span(),
                      wide_time(), batch_left == 0);
    end
    if (roll < 86) begin
      return make_cmd(OP_CLEAR, pick_pos(), pick_pos(), pick_span(), pick_span(),
                      wide_time(), 1'($urandom_range(0, 1)));
    end
    if (roll < 90) begin
      return make_cmd(OP_SPARE, pick_pos(), pick_pos(), pick_span(), pick_span(),
                      wide_time(), 1'($urandom_range(0, 1)));
    end
    cmd = in_item_t'(IN_W'({$urandom(), $urandom(), $urandom(), $urandom()}));
    return cmd;
  endfunction

  // Offers one item and waits until the block takes it.
  task automatic send_cmd(in_item_t cmd);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_command(cmd);
  endtask

  // Withdraws the sender and waits for every outstanding result.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Main sequence.
  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: clear, spare opcode with every bit set, patch that finds nothing.
    send_cmd(make_cmd(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_SPARE, '1, '1, '1, '1, '1, 1'b1));
    send_cmd(make_cmd(OP_PATCH, '0, '0, '1, '1, '0, 1'b1));

    // Zero-sized, maximal and ordinary rectangles.
    send_cmd(make_cmd(OP_ADD, '0, '0, '0, '0, '0, 1'b0));
    send_cmd(make_cmd(OP_ADD, '1, '1, '1, '1, '1, 1'b0));
    send_cmd(make_cmd(OP_ADD, 12'd10, 12'd10, 12'd20, 12'd20, 48'd5, 1'b1));

    // A patch that only touches an edge clears nothing; a zero-width patch
    // inside the ordinary entry still takes it under the strict test.
    send_cmd(make_cmd(OP_PATCH, 12'd30, 12'd10, 12'd5, 12'd5, 48'd6, 1'b0));
    send_cmd(make_cmd(OP_PATCH, 12'd15, 12'd15, 12'd0, 12'd50, 48'd6, 1'b0));

    // A huge patch takes the maximal entry but not the zero-sized one.
    send_cmd(make_cmd(OP_PATCH, 12'd1, 12'd1, '1, '1, 48'd6, 1'b1));

    // Fill the table, evict the oldest, then evict on a tie of times.
    for (int i = 0; i < 15; i++) begin
      send_cmd(make_cmd(OP_ADD, pick_pos(), pick_pos(), pick_span(), pick_span(),
                        48'd7, 1'b0));
    end
    send_cmd(make_cmd(OP_ADD, 12'd40, 12'd40, 12'd8, 12'd8, 48'd7, 1'b0));
    send_cmd(make_cmd(OP_ADD, 12'd50, 12'd50, 12'd8, 12'd8, 48'd7, 1'b1));
    send_cmd(make_cmd(OP_CLEAR, '1, '1, '1, '1, '1, 1'b1));

    // Let the block drain completely before the random part.
    settle();

    clock_us = 48'd100;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 400 && n < 600);
      send_cmd(random_cmd());
    end
    calm = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d adds with %0d evictions, %0d patches dropping %0d",
             board.checked, board.adds, board.evictions, board.patches, board.patch_hits);
    $display("entries, %0d clears, %0d spare-opcode items; %0d mismatches.",
             board.clears, board.spares, board.errors);
    if (board.errors == 0) begin
      $display("dirty_rect_ledger regression: pass");
    end else begin
      $display("dirty_rect_ledger regression: fail");
    end
    $finish;
  end

endmodule

@@ dirty_rect_ledger.f @@
hw/rtl/dlr_pkg.sv
hw/rtl/dlr_ram.sv
hw/rtl/dlr_cmp_unit.sv
hw/rtl/dirty_rect_ledger.sv
hw/rtl/dlr_checker.sv
bench/dirty_rect_ledger_tb.sv
